[design/lac_pkg.sv]
// ----------------------------------------------------------------------------
// lac_pkg
// Shared types, register codes, color constants and helper functions of the
// layered alpha compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package lac_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_W      = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd2;

    localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 13'd768;

    localparam logic FMT_RGB = 1'b0;

    localparam int QUOT_BITS   = 8;
    localparam int DIV_STAGES  = QUOT_BITS + 1;
    localparam int PIPE_STAGES = 20;
    localparam int NUM_LAYERS  = 4;

    localparam int LAYER_BACK    = 0;
    localparam int LAYER_FRONT   = 1;
    localparam int LAYER_TASKBAR = 2;
    localparam int LAYER_CURSOR  = 3;

    localparam int ACCENT_ROW_PCT  = 52;
    localparam int ACCENT_GAP      = 38;
    localparam int ACCENT_A_LO_PCT = 18;
    localparam int ACCENT_A_HI_PCT = 90;
    localparam int ACCENT_B_LO_PCT = 22;
    localparam int ACCENT_B_HI_PCT = 84;

    localparam int SCALED_W    = 20;
    localparam int RECIP_W     = 18;
    localparam int RECIP_100   = 167772;
    localparam int RECIP_SHIFT = 24;
    localparam int QUOT100_W   = 14;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef logic [NUM_LAYERS-1:0][31:0] layer_set_t;

    typedef struct packed {
        logic [CFG_W-1:0] row_a;
        logic [CFG_W-1:0] row_b;
        logic [CFG_W-1:0] col_a_lo;
        logic [CFG_W-1:0] col_a_hi;
        logic [CFG_W-1:0] col_b_lo;
        logic [CFG_W-1:0] col_b_hi;
    } accent_t;

    localparam rgb_t GRAD_TOP = '{r: 8'd11, g: 8'd79, b: 8'd130};
    localparam rgb_t GRAD_BOT = '{r: 8'd6, g: 8'd27, b: 8'd49};
    localparam rgb_t ACCENT_A = '{r: 8'd56, g: 8'd126, b: 8'd164};
    localparam rgb_t ACCENT_B = '{r: 8'd42, g: 8'd104, b: 8'd146};

    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return s[15:8];
    endfunction

    function automatic logic [15:0] grad_num(input logic [7:0] top, input logic [7:0] bot,
                                              input logic [7:0] t);
        logic [7:0] diff;
        diff = top - bot;
        return ({8'd0, top} * 16'd255) - ({8'd0, diff} * {8'd0, t});
    endfunction

endpackage

`default_nettype wire

[design/lac_if.sv]
// ----------------------------------------------------------------------------
// lac_if
// Handshake channels of the compositor: layer samples in, packed pixels out,
// and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lac_in_if #(parameter int COORD_BITS = 12) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [31:0]           window_a_pixel;
    logic [31:0]           window_b_pixel;
    logic [31:0]           taskbar_pixel;
    logic [31:0]           cursor_pixel;
    logic                  window_a_visible;
    logic                  window_b_visible;
    logic                  front_is_a;

    modport source (
        output valid, pix_x, pix_y, window_a_pixel, window_b_pixel, taskbar_pixel,
               cursor_pixel, window_a_visible, window_b_visible, front_is_a,
        input  ready
    );
    modport sink (
        input  valid, pix_x, pix_y, window_a_pixel, window_b_pixel, taskbar_pixel,
               cursor_pixel, window_a_visible, window_b_visible, front_is_a,
        output ready
    );
endinterface

interface lac_out_if ();
    logic        valid;
    logic        ready;
    logic [23:0] out_pixel;

    modport source (output valid, out_pixel, input ready);
    modport sink (input valid, out_pixel, output ready);
endinterface

interface lac_cfg_if import lac_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/lac_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lac_cfg_regs
// Screen geometry and format registers, and the accent line limits that
// follow from the geometry, worked out over a short pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_cfg_regs import lac_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    lac_cfg_if.sink          cfg,
    output logic [CFG_W-1:0] screen_height,
    output logic             pixel_format,
    output accent_t          accent
);

    localparam int TERMS = 5;

    logic [CFG_W-1:0]                 width_reg;
    logic [CFG_W-1:0]                 height_reg;
    logic                             format_reg;
    logic [SCALED_W-1:0]              scaled_next [0:TERMS-1];
    logic [SCALED_W-1:0]              scaled_reg [0:TERMS-1];
    logic [SCALED_W-1:0]              scaled_d_reg [0:TERMS-1];
    logic [SCALED_W+RECIP_W-1:0]      prod_reg [0:TERMS-1];
    logic [CFG_W-1:0]                 quot_reg [0:TERMS-1];
    accent_t                          accent_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            format_reg <= FMT_RGB;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg.data;
                REG_SCREEN_HEIGHT: height_reg <= cfg.data;
                REG_PIXEL_FORMAT:  format_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        scaled_next[0] = SCALED_W'(height_reg) * SCALED_W'(ACCENT_ROW_PCT);
        scaled_next[1] = SCALED_W'(width_reg) * SCALED_W'(ACCENT_A_LO_PCT);
        scaled_next[2] = SCALED_W'(width_reg) * SCALED_W'(ACCENT_A_HI_PCT);
        scaled_next[3] = SCALED_W'(width_reg) * SCALED_W'(ACCENT_B_LO_PCT);
        scaled_next[4] = SCALED_W'(width_reg) * SCALED_W'(ACCENT_B_HI_PCT);
    end

    // Division by 100 uses a reciprocal that undershoots by at most one, so a
    // single remainder check completes it.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TERMS; i++)
        begin
            logic [QUOT100_W-1:0] q0;
            logic [SCALED_W-1:0]  rem;
            q0 = prod_reg[i][RECIP_SHIFT +: QUOT100_W];
            rem = scaled_d_reg[i] - SCALED_W'(q0) * SCALED_W'(100);
            scaled_reg[i]   <= scaled_next[i];
            scaled_d_reg[i] <= scaled_reg[i];
            prod_reg[i]     <= (SCALED_W+RECIP_W)'(scaled_reg[i]) *
                               (SCALED_W+RECIP_W)'(RECIP_100);
            quot_reg[i]     <= (rem >= SCALED_W'(100)) ? CFG_W'(q0 + QUOT100_W'(1))
                                                       : CFG_W'(q0);
        end
        accent_reg.row_a    <= quot_reg[0];
        accent_reg.row_b    <= quot_reg[0] + CFG_W'(ACCENT_GAP);
        accent_reg.col_a_lo <= quot_reg[1];
        accent_reg.col_a_hi <= quot_reg[2];
        accent_reg.col_b_lo <= quot_reg[3];
        accent_reg.col_b_hi <= quot_reg[4];
    end

    assign screen_height = height_reg;
    assign pixel_format  = format_reg;
    assign accent        = accent_reg;

endmodule

`default_nettype wire

[design/lac_row_div.sv]
// ----------------------------------------------------------------------------
// lac_row_div
// Pipelined restoring divider for the gradient position: row*255 over the
// screen height, with a saturation check and one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_row_div import lac_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [CFG_W-1:0]      screen_height,
    input  logic [COORD_BITS+7:0] num_in,
    input  logic [COORD_BITS-1:0] x_in,
    input  logic [COORD_BITS-1:0] y_in,
    input  layer_set_t            layers_in,
    output logic [QUOT_BITS-1:0]  quot_out,
    output logic                  sat_out,
    output logic [COORD_BITS-1:0] x_out,
    output logic [COORD_BITS-1:0] y_out,
    output layer_set_t            layers_out
);

    localparam int NUM_W = COORD_BITS + 8;
    localparam int DEN_W = CFG_W + QUOT_BITS;
    localparam int WW    = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [CFG_W-1:0]      den;
    logic [WW-1:0]         rem_reg [0:DIV_STAGES-1];
    logic [QUOT_BITS-1:0]  quot_reg [0:DIV_STAGES-1];
    logic                  sat_reg [0:DIV_STAGES-1];
    logic [COORD_BITS-1:0] x_reg [0:DIV_STAGES-1];
    logic [COORD_BITS-1:0] y_reg [0:DIV_STAGES-1];
    layer_set_t            layers_reg [0:DIV_STAGES-1];

    assign den = (screen_height == '0) ? CFG_W'(1) : screen_height;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]    <= WW'(num_in);
            sat_reg[0]    <= WW'(num_in) >= (WW'(den) << QUOT_BITS);
            quot_reg[0]   <= '0;
            x_reg[0]      <= x_in;
            y_reg[0]      <= y_in;
            layers_reg[0] <= layers_in;
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++)
    begin : g_step
        localparam int K = QUOT_BITS - j;
        logic [WW-1:0]        dsh;
        logic                 fit;
        logic [QUOT_BITS-1:0] quot_next;

        assign dsh       = WW'(den) << K;
        assign fit       = rem_reg[j-1] >= dsh;
        assign quot_next = quot_reg[j-1] | (QUOT_BITS'(fit) << K);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]     <= fit ? (rem_reg[j-1] - dsh) : rem_reg[j-1];
                quot_reg[j]    <= quot_next;
                sat_reg[j]     <= sat_reg[j-1];
                x_reg[j]       <= x_reg[j-1];
                y_reg[j]       <= y_reg[j-1];
                layers_reg[j]  <= layers_reg[j-1];
            end
        end
    end

    assign quot_out   = quot_reg[DIV_STAGES-1];
    assign sat_out    = sat_reg[DIV_STAGES-1];
    assign x_out      = x_reg[DIV_STAGES-1];
    assign y_out      = y_reg[DIV_STAGES-1];
    assign layers_out = layers_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

[design/lac_background.sv]
// ----------------------------------------------------------------------------
// lac_background
// Vertical gradient color from the row position, overridden by the two
// accent lines, over two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_background import lac_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  en,
    input  accent_t               accent,
    input  logic [QUOT_BITS-1:0]  quot_in,
    input  logic                  sat_in,
    input  logic [COORD_BITS-1:0] x_in,
    input  logic [COORD_BITS-1:0] y_in,
    input  layer_set_t            layers_in,
    output rgb_t                  rgb_out,
    output layer_set_t            layers_out
);

    localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

    logic [7:0]  t;
    logic        on_a;
    logic        on_b;
    logic [15:0] num_r_reg;
    logic [15:0] num_g_reg;
    logic [15:0] num_b_reg;
    logic        on_a_reg;
    logic        on_b_reg;
    layer_set_t  layers_a_reg;
    rgb_t        rgb_reg;
    layer_set_t  layers_b_reg;

    assign t = sat_in ? 8'hFF : quot_in;

    assign on_a = (CMP_W'(y_in) == CMP_W'(accent.row_a)) &&
                  (CMP_W'(x_in) > CMP_W'(accent.col_a_lo)) &&
                  (CMP_W'(x_in) < CMP_W'(accent.col_a_hi));
    assign on_b = (CMP_W'(y_in) == CMP_W'(accent.row_b)) &&
                  (CMP_W'(x_in) > CMP_W'(accent.col_b_lo)) &&
                  (CMP_W'(x_in) < CMP_W'(accent.col_b_hi));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_r_reg    <= grad_num(GRAD_TOP.r, GRAD_BOT.r, t);
            num_g_reg    <= grad_num(GRAD_TOP.g, GRAD_BOT.g, t);
            num_b_reg    <= grad_num(GRAD_TOP.b, GRAD_BOT.b, t);
            on_a_reg     <= on_a;
            on_b_reg     <= on_b;
            layers_a_reg <= layers_in;

            if (on_b_reg)
                rgb_reg <= ACCENT_B;
            else if (on_a_reg)
                rgb_reg <= ACCENT_A;
            else
                rgb_reg <= '{r: div255(num_r_reg), g: div255(num_g_reg),
                             b: div255(num_b_reg)};
            layers_b_reg <= layers_a_reg;
        end
    end

    assign rgb_out    = rgb_reg;
    assign layers_out = layers_b_reg;

endmodule

`default_nettype wire

[design/lac_blend.sv]
// ----------------------------------------------------------------------------
// lac_blend
// One layer blend: weighted channel sums in the first stage, division by
// 255 in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_blend import lac_pkg::*; (
    input  logic       clk,
    input  logic       en,
    input  rgb_t       below,
    input  logic [31:0] above,
    input  layer_set_t layers_in,
    output rgb_t       rgb_out,
    output layer_set_t layers_out
);

    logic [7:0]  alpha;
    logic [7:0]  inv_alpha;
    logic [15:0] sum_r_reg;
    logic [15:0] sum_g_reg;
    logic [15:0] sum_b_reg;
    layer_set_t  layers_a_reg;
    rgb_t        rgb_reg;
    layer_set_t  layers_b_reg;

    assign alpha     = above[31:24];
    assign inv_alpha = 8'd255 - alpha;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_r_reg <= 16'(above[23:16]) * 16'(alpha) + 16'(below.r) * 16'(inv_alpha);
            sum_g_reg <= 16'(above[15:8]) * 16'(alpha) + 16'(below.g) * 16'(inv_alpha);
            sum_b_reg <= 16'(above[7:0]) * 16'(alpha) + 16'(below.b) * 16'(inv_alpha);
            layers_a_reg <= layers_in;

            rgb_reg <= '{r: div255(sum_r_reg), g: div255(sum_g_reg),
                         b: div255(sum_b_reg)};
            layers_b_reg <= layers_a_reg;
        end
    end

    assign rgb_out    = rgb_reg;
    assign layers_out = layers_b_reg;

endmodule

`default_nettype wire

[design/lac_flow_ctrl.sv]
// ----------------------------------------------------------------------------
// lac_flow_ctrl
// Valid bits of the pipeline stages, the output register with its skid
// entry, and the final channel packing.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_flow_ctrl import lac_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_ready,
    input  rgb_t        rgb_last,
    input  logic        pixel_format,
    output logic        en,
    output logic        out_valid,
    output logic [23:0] out_pixel
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic [23:0]            out_data_reg;
    logic [23:0]            skid_data_reg;
    logic [23:0]            packed_pix;
    logic                   arriving;

    assign en         = !skid_valid_reg;
    assign arriving   = en && valid_reg[PIPE_STAGES-1];
    assign packed_pix = (pixel_format == FMT_RGB) ? {rgb_last.b, rgb_last.g, rgb_last.r}
                                                  : {rgb_last.r, rgb_last.g, rgb_last.b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                valid_reg <= {valid_reg[PIPE_STAGES-2:0], in_valid};

            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= arriving;
            end
            else if (arriving)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (arriving)
                out_data_reg <= packed_pix;
        end
        else if (arriving)
            skid_data_reg <= packed_pix;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_data_reg;

endmodule

`default_nettype wire

[design/layered_alpha_compositor.sv]
// ----------------------------------------------------------------------------
// layered_alpha_compositor
// Composes one screen pixel from a gradient background, two windows, a
// taskbar and a cursor, and packs it as RGB or BGR.
// ----------------------------------------------------------------------------
// The compositor takes one pixel per clock while its skid entry is empty. The
// pipeline depth is set by the input register and the row divider for the
// gradient, which resolves one quotient bit per stage, followed by two
// background stages and two stages for each of the four layer blends. An
// output register with one skid entry keeps input transfers flowing for one
// more pixel while the output side stalls. After a register write the accent
// line limits are recomputed through the registers of lac_cfg_regs.
`default_nettype none

module layered_alpha_compositor import lac_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    lac_cfg_if.sink    cfg,
    lac_in_if.sink     sample,
    lac_out_if.source  pixel
);

    localparam int NUM_W = COORD_BITS + 8;

    logic                  en;
    logic [CFG_W-1:0]      screen_height;
    logic                  pixel_format;
    accent_t               accent;

    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [NUM_W-1:0]      num_reg;
    layer_set_t            layers_reg;
    logic [31:0]           win_a;
    logic [31:0]           win_b;

    logic [QUOT_BITS-1:0]  div_quot;
    logic                  div_sat;
    logic [COORD_BITS-1:0] div_x;
    logic [COORD_BITS-1:0] div_y;
    layer_set_t            div_layers;

    rgb_t                  stage_rgb [0:NUM_LAYERS];
    layer_set_t            stage_layers [0:NUM_LAYERS];

    lac_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .screen_height (screen_height),
        .pixel_format  (pixel_format),
        .accent        (accent)
    );

    assign sample.ready = en;

    assign win_a = sample.window_a_visible ? sample.window_a_pixel : 32'd0;
    assign win_b = sample.window_b_visible ? sample.window_b_pixel : 32'd0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= sample.pix_x;
            y_reg   <= sample.pix_y;
            num_reg <= {sample.pix_y, 8'd0} - NUM_W'(sample.pix_y);
            layers_reg[LAYER_BACK]    <= sample.front_is_a ? win_b : win_a;
            layers_reg[LAYER_FRONT]   <= sample.front_is_a ? win_a : win_b;
            layers_reg[LAYER_TASKBAR] <= sample.taskbar_pixel;
            layers_reg[LAYER_CURSOR]  <= sample.cursor_pixel;
        end
    end

    lac_row_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk           (clk),
        .en            (en),
        .screen_height (screen_height),
        .num_in        (num_reg),
        .x_in          (x_reg),
        .y_in          (y_reg),
        .layers_in     (layers_reg),
        .quot_out      (div_quot),
        .sat_out       (div_sat),
        .x_out         (div_x),
        .y_out         (div_y),
        .layers_out    (div_layers)
    );

    lac_background #(.COORD_BITS(COORD_BITS)) u_bg (
        .clk        (clk),
        .en         (en),
        .accent     (accent),
        .quot_in    (div_quot),
        .sat_in     (div_sat),
        .x_in       (div_x),
        .y_in       (div_y),
        .layers_in  (div_layers),
        .rgb_out    (stage_rgb[0]),
        .layers_out (stage_layers[0])
    );

    for (genvar k = 0; k < NUM_LAYERS; k++)
    begin : g_layer
        lac_blend u_blend (
            .clk        (clk),
            .en         (en),
            .below      (stage_rgb[k]),
            .above      (stage_layers[k][k]),
            .layers_in  (stage_layers[k]),
            .rgb_out    (stage_rgb[k+1]),
            .layers_out (stage_layers[k+1])
        );
    end

    lac_flow_ctrl u_flow (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample.valid),
        .out_ready    (pixel.ready),
        .rgb_last     (stage_rgb[NUM_LAYERS]),
        .pixel_format (pixel_format),
        .en           (en),
        .out_valid    (pixel.valid),
        .out_pixel    (pixel.out_pixel)
    );

endmodule

`default_nettype wire

[design/lac_checker.sv]
// ----------------------------------------------------------------------------
// lac_checker
// Port-level checks of the compositor's output register and input
// back-pressure, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] out_pixel
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output transfer withdrawn while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pixel))
        else $error("Output pixel changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input held off with no result waiting.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("Input held off without an output stall.");

endmodule

bind layered_alpha_compositor lac_checker u_lac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .out_pixel (pixel.out_pixel)
);

`default_nettype wire
